@@ src/integer_to_ascii_formatter_assert.svh @@
// assertion macros used by the formatter rtl
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define I2A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2A_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/i2a_pkg.sv @@
package i2a_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BIN_W   = 32;
    localparam int unsigned BCD_DIG = 10;
    localparam int unsigned HEX_DIG = VALUE_W / 4;

    localparam logic [2:0] REQ_UDEC  = 3'd0;
    localparam logic [2:0] REQ_SDEC  = 3'd1;
    localparam logic [2:0] REQ_HEXL  = 3'd2;
    localparam logic [2:0] REQ_HEXU  = 3'd3;
    localparam logic [2:0] REQ_PTR   = 3'd4;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_X     = 8'h78;
    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_LA    = 8'h61;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // converter status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } dab_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        if (nib < 4'd10) begin
            digit_char = CHR_ZERO + {4'b0000, nib};
        end
        else begin
            base = upper ? CHR_UA : CHR_LA;
            digit_char = base + {4'b0000, nib} - 8'd10;
        end
    endfunction

endpackage

@@ src/i2a_dabble.sv @@
module i2a_dabble (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [i2a_pkg::BIN_W-1:0] bin,
    output i2a_pkg::dab_stat_t        stat,
    output logic [4*i2a_pkg::BCD_DIG-1:0] bcd
);
    import i2a_pkg::*;

    localparam int unsigned CNT_W = $clog2(BIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BIN_W - 1);

    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic [4*BCD_DIG-1:0] bcd_reg, bcd_next;
    logic [4*BCD_DIG-1:0] adj;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // add-3 on every digit at five or more, ahead of the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIG; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[4*BCD_DIG-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

@@ src/integer_to_ascii_formatter.sv @@
// channel  | signals                                 | role
// ---------+-----------------------------------------+------------------------------
// in       | in_valid, in_ready, value, req_type     | one integer and its format
// out      | out_valid, out_ready, char_code,        | one ascii character per word
//          | char_position, is_last                  |
//
// one word in at a time; the next is taken once the last character sits in the
// output register. decimal: accept, bit-serial double dabble of the low half
// (one value bit per cycle), drop leading zeros (up to 9), leave the zero drop,
// then send the characters, with a minus sign first for a negative signed value.
// hex: accept, drop leading zeros (up to 15), leave the zero drop, send; pointer adds 0x.
// a stalled out_ready holds the character and the digit shift register.
// reset clears the sequencer and output valid; no memories, nothing to sweep.
module integer_to_ascii_formatter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [i2a_pkg::VALUE_W-1:0] value,
    input  logic [2:0]                  req_type,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  char_code,
    output logic [4:0]                  char_position,
    output logic                        is_last
);
    import i2a_pkg::*;

    `include "integer_to_ascii_formatter_assert.svh"

    localparam int unsigned NDIG_W = $clog2(HEX_DIG + 1);

    state_t state_reg, state_next;

    // prefix: count of chars still to send, and whether it is "0x" or "-"
    logic [1:0]         pre_cnt_reg, pre_cnt_next;
    logic               pre_ptr_reg, pre_ptr_next;
    logic               upper_reg, upper_next;

    // digits, most significant nibble on top, and how many are left
    logic [VALUE_W-1:0] dig_reg, dig_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic [4:0]         pos_reg, pos_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_code_reg, out_code_next;
    logic [4:0]         out_pos_reg, out_pos_next;
    logic               out_last_reg, out_last_next;

    logic               in_acc;
    logic               is_dec;
    logic               neg;
    logic [BIN_W-1:0]   low_mag;
    logic               dab_start;
    dab_stat_t          dab_stat;
    logic [4*BCD_DIG-1:0] bcd;
    logic               load;
    logic [7:0]         cur_char;
    logic               cur_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign is_dec   = (req_type == REQ_UDEC) || (req_type == REQ_SDEC);
    assign neg      = (req_type == REQ_SDEC) && value[BIN_W-1];
    // two's complement magnitude; the most negative value comes out as 2^31
    assign low_mag  = neg ? (BIN_W'(0) - value[BIN_W-1:0]) : value[BIN_W-1:0];
    assign dab_start = in_acc && is_dec;

    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .bin   (low_mag),
        .stat  (dab_stat),
        .bcd   (bcd)
    );

    // next character: prefix first, then the top digit
    always_comb
    begin
        if (pre_cnt_reg != 2'd0)
        begin
            if (pre_ptr_reg)
                cur_char = (pre_cnt_reg == 2'd2) ? CHR_ZERO : CHR_X;
            else
                cur_char = CHR_MINUS;
        end
        else
        begin
            cur_char = digit_char(dig_reg[VALUE_W-1 -: 4], upper_reg);
        end
    end

    assign cur_last = (pre_cnt_reg == 2'd0) && (ndig_reg == NDIG_W'(1));
    assign load     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        pre_cnt_next   = pre_cnt_reg;
        pre_ptr_next   = pre_ptr_reg;
        upper_next     = upper_reg;
        dig_next       = dig_reg;
        ndig_next      = ndig_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_code_next  = out_code_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                pos_next = 5'd0;
                if (in_acc)
                begin
                    // unused format codes are dropped without output
                    priority if (is_dec)
                    begin
                        pre_cnt_next = {1'b0, neg};
                        pre_ptr_next = 1'b0;
                        upper_next   = 1'b0;
                        state_next   = ST_CONV;
                    end
                    else if ((req_type == REQ_HEXL) || (req_type == REQ_HEXU) ||
                             (req_type == REQ_PTR))
                    begin
                        pre_cnt_next = (req_type == REQ_PTR) ? 2'd2 : 2'd0;
                        pre_ptr_next = (req_type == REQ_PTR);
                        upper_next   = (req_type == REQ_HEXU);
                        dig_next     = value;
                        ndig_next    = NDIG_W'(HEX_DIG);
                        state_next   = ST_SKIP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CONV:
            begin
                if (dab_stat.done)
                begin
                    dig_next   = {bcd, {(VALUE_W - 4*BCD_DIG){1'b0}}};
                    ndig_next  = NDIG_W'(BCD_DIG);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if ((ndig_reg > NDIG_W'(1)) && (dig_reg[VALUE_W-1 -: 4] == 4'd0))
                begin
                    dig_next  = {dig_reg[VALUE_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = cur_char;
                    out_pos_next   = pos_reg;
                    out_last_next  = cur_last;
                    pos_next       = pos_reg + 1'b1;
                    if (pre_cnt_reg != 2'd0)
                    begin
                        pre_cnt_next = pre_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        dig_next  = {dig_reg[VALUE_W-5:0], 4'd0};
                        ndig_next = ndig_reg - 1'b1;
                    end
                    if (cur_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pre_cnt_reg   <= 2'd0;
            ndig_reg      <= '0;
            pos_reg       <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pre_cnt_reg   <= pre_cnt_next;
            ndig_reg      <= ndig_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_ptr_reg  <= pre_ptr_next;
        upper_reg    <= upper_next;
        dig_reg      <= dig_next;
        out_code_reg <= out_code_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign char_code     = out_code_reg;
    assign char_position = out_pos_reg;
    assign is_last       = out_last_reg;

    // digit count never runs dry while characters are still owed
    `I2A_ASSERT_IMP(a_emit_has_digit, clk, rst_n, state_reg == ST_EMIT,
        ndig_reg != '0, "emit state with no digits left")
    // the converter only reports done while the sequencer waits for it
    `I2A_ASSERT_IMP(a_done_in_conv, clk, rst_n, dab_stat.done,
        state_reg == ST_CONV, "converter done outside conversion")
    // waiting for the converter implies it is running or just finished
    `I2A_ASSERT_IMP(a_conv_active, clk, rst_n, state_reg == ST_CONV,
        dab_stat.busy || dab_stat.done, "conversion state with idle converter")
    // text never exceeds eighteen characters
    `I2A_ASSERT_IMP(a_pos_range, clk, rst_n, out_valid_reg,
        out_pos_reg < 5'd18, "character position out of range")
    // a last character always returns the sequencer to idle
    `I2A_ASSERT_NXT(a_last_to_idle, clk, rst_n, load && cur_last,
        state_reg == ST_IDLE, "last character did not end the word")

endmodule

@@ verif/tb_integer_to_ascii_formatter.sv @@
module tb_integer_to_ascii_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    import i2a_pkg::*;

    // format codes the block has no use for: accepted, nothing emitted
    localparam logic [2:0] REQ_SPARE5 = 3'd5;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    // marks a table row whose text comes from the predictor, never a real output
    localparam string FROM_PREDICTOR = "?";

    localparam int RANDOM_WORDS = 110;
    localparam int DRAIN_CYCLES = 80;

    // one expected character word
    typedef struct {
        logic [7:0] code;
        logic [4:0] pos;
        logic       last;
    } char_word_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [VALUE_W-1:0]  value;
    logic [2:0]          req_type;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          char_code;
    logic [4:0]          char_position;
    logic                is_last;

    char_word_t pending_chars[$];
    int         mismatch_count = 0;
    int         words_in = 0;
    int         burst_left = 0;
    // text the sender claims for the word it is offering right now
    string      offered_text = FROM_PREDICTOR;

    integer_to_ascii_formatter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .req_type      (req_type),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_code     (char_code),
        .char_position (char_position),
        .is_last       (is_last)
    );

    always #5 clk = ~clk;

    // directed table: extremes of every format, sign corner, zero, spare codes
    localparam int DIR_N = 25;
    logic [63:0] dir_value [DIR_N] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'hDEAD_BEEF_0000_0007,
        64'd1000000000,          64'd10,
        64'h0000_0000_0000_0000, 64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0001, 64'h0000_0000_FFFF_FFF6,
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210,
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_1234, 64'h0000_0000_0000_0000,
        64'h5555_5555_1234_5678, 64'hAAAA_AAAA_C0DE_CAFE
    };
    logic [2:0] dir_fmt [DIR_N] = '{
        REQ_UDEC, REQ_UDEC, REQ_UDEC, REQ_UDEC, REQ_UDEC,
        REQ_SDEC, REQ_SDEC, REQ_SDEC, REQ_SDEC, REQ_SDEC, REQ_SDEC,
        REQ_HEXL, REQ_HEXL, REQ_HEXL,
        REQ_HEXU, REQ_HEXU, REQ_HEXU,
        REQ_PTR,  REQ_PTR,  REQ_PTR,
        REQ_SPARE5, REQ_SPARE6, REQ_SPARE7,
        REQ_UDEC, REQ_SDEC
    };
    string dir_text [DIR_N] = '{
        "0", "4294967295", "7", "1000000000", "10",
        "0", "-2147483648", "2147483647", "-1", "1", "-10",
        "0", "ffffffffffffffff", "123456789abcdef",
        "0", "FFFFFFFFFFFFFFFF", "FEDCBA9876543210",
        "0x0", "0xffffffffffffffff", "0x8000000000000000",
        "", "", "",
        FROM_PREDICTOR, FROM_PREDICTOR
    };

    // text the block should emit for one word
    function automatic string spell_value(input logic [63:0] v, input logic [2:0] fmt);
        string       digits;
        string       prefix;
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] d;
        logic [31:0] low;
        logic [7:0]  ch;
        logic        upper;
        digits = "";
        prefix = "";
        upper  = (fmt == REQ_HEXU);
        case (fmt)
            REQ_UDEC, REQ_SDEC:
            begin
                // decimal only looks at the low half
                low = v[31:0];
                if (fmt == REQ_SDEC && low[31])
                begin
                    prefix = "-";
                    low    = -low;
                end
                mag   = {32'd0, low};
                radix = 64'd10;
            end
            REQ_HEXL, REQ_HEXU:
            begin
                mag   = v;
                radix = 64'd16;
            end
            REQ_PTR:
            begin
                prefix = "0x";
                mag    = v;
                radix  = 64'd16;
            end
            default:
                return "";
        endcase
        // least significant digit first, prepended, so zero still gives one digit
        do
        begin
            d = mag % radix;
            if (d < 64'd10)
                ch = "0" + d[7:0];
            else if (upper)
                ch = "A" + d[7:0] - 8'd10;
            else
                ch = "a" + d[7:0] - 8'd10;
            digits = {$sformatf("%c", ch), digits};
            mag    = mag / radix;
        end
        while (mag != 64'd0);
        return {prefix, digits};
    endfunction

    // one expected word per character, numbered from zero, last one flagged
    task automatic queue_text_chars(input string txt);
        char_word_t w;
        for (int i = 0; i < txt.len(); i++)
        begin
            w.code = txt[i];
            w.pos  = i[4:0];
            w.last = (i == txt.len() - 1);
            pending_chars.push_back(w);
        end
    endtask

    task automatic flag_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // both channels seen at the rising edge, input side first
    always @(posedge clk)
    begin
        char_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                words_in++;
                if (offered_text == FROM_PREDICTOR)
                    queue_text_chars(spell_value(value, req_type));
                else
                    queue_text_chars(offered_text);
            end
            if (out_valid && out_ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual code %0h pos %0d",
                             $time, char_code, char_position);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (char_code !== want.code)
                        flag_field("char_code", want.code, char_code);
                    if (char_position !== want.pos)
                        flag_field("char_position", {3'd0, want.pos}, {3'd0, char_position});
                    if (is_last !== want.last)
                        flag_field("is_last", {7'd0, want.last}, {7'd0, is_last});
                end
            end
        end
    end

    // offer one word at the falling edge, hold it until taken; bursts with gaps
    task automatic send_word(input logic [63:0] v, input logic [2:0] fmt, input string txt);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            // long bursts now and then leave stretches with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        value        <= v;
        req_type     <= fmt;
        offered_text  = txt;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // receiver: phases of always ready, light stalls and heavy stalls, plus one
    // long hold-off while the sender keeps going so the input backs up
    initial
    begin
        int  phase_left;
        int  stall_mode;
        int  hold_left;
        bit  held_once;
        phase_left = 0;
        stall_mode = 0;
        hold_left  = 0;
        held_once  = 1'b0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held_once && words_in >= 40)
            begin
                held_once = 1'b1;
                hold_left = 300;
                out_ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 120);
                end
                phase_left--;
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // stimulus: directed table, then random words, then drain
    initial
    begin
        int          real_words;
        logic [63:0] v;
        logic [2:0]  fmt;
        int          pick;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;
        req_type = REQ_UDEC;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_word(dir_value[i], dir_fmt[i], dir_text[i]);

        // random words; spare format codes mixed in but not counted
        real_words = 0;
        while (real_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 14)
                fmt = 3'(pick % 5);
            else
                fmt = 3'(REQ_SPARE5 + $urandom_range(0, 2));
            // spread magnitudes so every digit count shows up
            case ($urandom_range(0, 7))
                0:       v = 64'd0;
                1:       v = 64'hFFFF_FFFF_FFFF_FFFF;
                2:       v = 64'd1 << $urandom_range(0, 63);
                3:       v = {$urandom, 1'b1, 31'($urandom)};
                default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            send_word(v, fmt, FROM_PREDICTOR);
            if (fmt <= REQ_PTR)
                real_words++;
        end

        // half a cycle on, the last word has been logged by the monitor
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        // catch stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_integer_to_ascii_formatter: done, clean");
        else
            $display("tb_integer_to_ascii_formatter: done, errors");
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #(5_000_000);
        $display("tb_integer_to_ascii_formatter: done, errors");
        $finish;
    end

endmodule
